[sv/rtmu_pkg.sv]
// Types and codes shared by the routing table block and its entry memory.
// Depends on nothing.
package rtmu_pkg;

	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_UPDATE = 2'd1;
	localparam logic [1:0] OP_ADD    = 2'd2;

	localparam logic [1:0] ACT_NONE  = 2'd0;
	localparam logic [1:0] ACT_LOCAL = 2'd1;
	localparam logic [1:0] ACT_DIRECT = 2'd2;
	localparam logic [1:0] ACT_VIA   = 2'd3;

	localparam logic [2:0] ST_LOOKUP    = 3'd0;
	localparam logic [2:0] ST_UPDATED   = 3'd1;
	localparam logic [2:0] ST_UNCHANGED = 3'd2;
	localparam logic [2:0] ST_ADDED     = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;

	localparam int KIND_LOCAL_BIT = 0;
	localparam int KIND_HOST_BIT  = 1;
	localparam int KIND_BCAST_BIT = 2;

	localparam logic [15:0] METRIC_MAX = 16'hFFFF;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] address;
		logic [31:0] mask;
		logic [31:0] next_hop;
		logic [15:0] metric;
		logic [3:0]  interface_req;
		logic        kind_local;
		logic        kind_host;
		logic        kind_bcast;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic [7:0]  entry_index;
		logic [1:0]  action;
		logic [3:0]  out_interface;
		logic [31:0] forward_addr;
		logic [2:0]  status;
		logic [8:0]  entries_used;
	} rsp_t;

	typedef struct packed {
		logic [31:0] net;
		logic [31:0] netmask;
		logic [31:0] gateway;
		logic [15:0] cost;
		logic [3:0]  port;
		logic [2:0]  kind;
	} entry_t;

endpackage

[sv/route_table_match_update.sv]
// Routing table with first-match lookup, distance-vector update and static add.
// Depends on rtmu_pkg and rtmu_ram.
//
//   channel  payload          valid      ready      direction
//   req      rtmu_pkg::req_t  req_valid  req_ready  in
//   rsp      rtmu_pkg::rsp_t  rsp_valid  rsp_ready  out
//
// One word at a time: a word is held until its scan and resolve are done; the scan
// reads one entry a cycle from the memory, from index 0 up to the first match or the fill count.
// A new word is taken while the previous result still waits in the output register.
// Reset clears the fill count but not the memory; entries at or above it are never used.
// A stalled result holds the block in its resolve state until the slot frees.
module route_table_match_update #(
	parameter int TABLE_DEPTH = 256,
	parameter int PORT_COUNT  = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  rtmu_pkg::req_t   req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output rtmu_pkg::rsp_t   rsp
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
	localparam logic [8:0] PORT_LIM = 9'(PORT_COUNT);
	localparam logic [3:0] PORT_TOP = 4'(PORT_COUNT - 1);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_RESOLVE} state_t;

	state_t            state_q;
	logic [CW-1:0]     fill_q;
	logic [IW-1:0]     cmp_idx_q;
	logic              found_q;
	logic              rsp_valid_q;
	rtmu_pkg::rsp_t    rsp_q;
	rtmu_pkg::req_t    req_q;
	rtmu_pkg::entry_t  ent_q;

	rtmu_pkg::entry_t  rdata;
	rtmu_pkg::entry_t  wdata;
	logic [IW-1:0]     raddr;
	logic [IW-1:0]     waddr;
	logic              we;
	logic              mem_we;
	logic              out_load;
	logic              fill_inc;
	logic              match;
	logic              last;
	logic              room;
	logic [CW-1:0]     cmp_next;
	logic [CW-1:0]     fill_after;
	logic [3:0]        port_c;
	logic [15:0]       raised;
	logic [31:0]       lmask;
	logic              lrun;
	rtmu_pkg::rsp_t    rsp_n;

	rtmu_ram #(.DEPTH(TABLE_DEPTH)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	assign cmp_next = CW'(cmp_idx_q) + CW'(1);
	assign match = (req_q.address & rdata.netmask) == rdata.net;
	assign last = (cmp_next == fill_q);
	assign raddr = (state_q == S_SCAN) ? cmp_next[IW-1:0] : '0;
	assign room = (fill_q < DEPTH_C);
	assign out_load = (state_q == S_RESOLVE) && (!rsp_valid_q || rsp_ready);
	assign mem_we = we && out_load;
	assign fill_after = fill_q + CW'(fill_inc);

	assign port_c = ({5'd0, req_q.interface_req} >= PORT_LIM) ? PORT_TOP : req_q.interface_req;
	assign raised = (req_q.metric == rtmu_pkg::METRIC_MAX) ? rtmu_pkg::METRIC_MAX :
		req_q.metric + 16'd1;

	always_comb begin
		lmask = '0;
		lrun = 1'b1;
		for (int j = 0; j < 4; j++) begin
			if (req_q.address[31-8*j -: 8] == 8'd0) begin
				lrun = 1'b0;
			end
			if (lrun) begin
				lmask[31-8*j -: 8] = 8'hFF;
			end
		end
	end

	always_comb begin
		rsp_n = '0;
		we = 1'b0;
		fill_inc = 1'b0;
		waddr = cmp_idx_q;
		wdata = ent_q;
		rsp_n.status = rtmu_pkg::ST_UNCHANGED;
		case (req_q.opcode)
			rtmu_pkg::OP_LOOKUP: begin
				rsp_n.status = rtmu_pkg::ST_LOOKUP;
				rsp_n.hit = found_q;
				if (found_q) begin
					rsp_n.entry_index = 8'(cmp_idx_q);
					rsp_n.out_interface = ent_q.port;
					if (ent_q.kind[rtmu_pkg::KIND_LOCAL_BIT]) begin
						rsp_n.action = (ent_q.kind[rtmu_pkg::KIND_HOST_BIT] ||
							ent_q.kind[rtmu_pkg::KIND_BCAST_BIT]) ?
							rtmu_pkg::ACT_LOCAL : rtmu_pkg::ACT_DIRECT;
						rsp_n.forward_addr = req_q.address;
					end else begin
						rsp_n.action = rtmu_pkg::ACT_VIA;
						rsp_n.forward_addr = ent_q.gateway;
					end
				end
			end
			rtmu_pkg::OP_UPDATE: begin
				rsp_n.hit = found_q;
				if (found_q) begin
					rsp_n.entry_index = 8'(cmp_idx_q);
					if (raised < ent_q.cost) begin
						we = 1'b1;
						wdata.cost = raised;
						wdata.port = port_c;
						wdata.gateway = req_q.next_hop;
						rsp_n.status = rtmu_pkg::ST_UPDATED;
						rsp_n.out_interface = port_c;
						rsp_n.forward_addr = req_q.next_hop;
					end else begin
						rsp_n.out_interface = ent_q.port;
						rsp_n.forward_addr = ent_q.gateway;
					end
				end else if (room) begin
					we = 1'b1;
					fill_inc = 1'b1;
					waddr = fill_q[IW-1:0];
					wdata.net = req_q.address;
					wdata.netmask = lmask;
					wdata.gateway = req_q.next_hop;
					wdata.cost = raised;
					wdata.port = port_c;
					wdata.kind = 3'd0;
					rsp_n.status = rtmu_pkg::ST_ADDED;
					rsp_n.entry_index = 8'(fill_q);
					rsp_n.out_interface = port_c;
					rsp_n.forward_addr = req_q.next_hop;
				end else begin
					rsp_n.status = rtmu_pkg::ST_FULL;
				end
			end
			rtmu_pkg::OP_ADD: begin
				rsp_n.hit = found_q;
				if (room) begin
					we = 1'b1;
					fill_inc = 1'b1;
					waddr = fill_q[IW-1:0];
					wdata.net = req_q.address;
					wdata.netmask = req_q.mask;
					wdata.gateway = req_q.next_hop;
					wdata.cost = req_q.metric;
					wdata.port = port_c;
					wdata.kind = {req_q.kind_bcast, req_q.kind_host, req_q.kind_local};
					rsp_n.status = rtmu_pkg::ST_ADDED;
					rsp_n.entry_index = 8'(fill_q);
					rsp_n.out_interface = port_c;
					rsp_n.forward_addr = req_q.next_hop;
				end else begin
					rsp_n.status = rtmu_pkg::ST_FULL;
				end
			end
			default: begin
				rsp_n.status = rtmu_pkg::ST_UNCHANGED;
			end
		endcase
		rsp_n.entries_used = 9'(fill_after);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q <= '0;
			cmp_idx_q <= '0;
			found_q <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			if (out_load) begin
				rsp_valid_q <= 1'b1;
				rsp_q <= rsp_n;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						cmp_idx_q <= '0;
						found_q <= 1'b0;
						state_q <= (fill_q == '0) ? S_RESOLVE : S_SCAN;
					end
				end
				S_SCAN: begin
					if (match) begin
						found_q <= 1'b1;
						state_q <= S_RESOLVE;
					end else if (last) begin
						state_q <= S_RESOLVE;
					end else begin
						cmp_idx_q <= cmp_next[IW-1:0];
					end
				end
				S_RESOLVE: begin
					if (out_load) begin
						fill_q <= fill_after;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req;
		end
		if (state_q == S_SCAN && match) begin
			ent_q <= rdata;
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= DEPTH_C)
		else $error("fill count beyond table depth");

	a_scan_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (CW'(cmp_idx_q) < fill_q))
		else $error("scan index past fill count");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != $past(fill_q)) |-> (fill_q == $past(fill_q) + CW'(1) &&
			$past(out_load)))
		else $error("fill count moved without a resolved append");

	a_write_resolve: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_RESOLVE && !(req_valid && req_ready)))
		else $error("memory write outside resolve");

	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q == S_SCAN || state_q == S_RESOLVE))
		else $error("accepted word did not start a scan");

endmodule

[sv/rtmu_ram.sv]
// Route entry memory: one write port, one read port, registered read data.
// Depends on rtmu_pkg for the entry type.
module rtmu_ram #(
	parameter int DEPTH = 256
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  rtmu_pkg::entry_t           wdata,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output rtmu_pkg::entry_t           rdata
);

	rtmu_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
